### sv/spbc_pkg.sv
// Shared widths, register indexes and the queued command type for the scan
// point breakpoint clusterer. No dependencies.
package spbc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int CLUSTER_DEPTH = 32;

  localparam int CNT_W  = $clog2(CLUSTER_DEPTH + 1);
  localparam int IDX_W  = $clog2(CLUSTER_DEPTH);
  localparam int GAP_W  = 12;
  localparam int MINP_W = 6;
  localparam int CMP_W  = (CNT_W > MINP_W) ? CNT_W : MINP_W;
  localparam int NUM_W  = 8;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int T2_W   = 2 * GAP_W;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + NUM_W + 7) / 8) * 8;
  localparam int USER_W     = 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = GAP_W;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN = CFG_IDX_W'(1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         brk;
    logic                         fin;
  } cmd_t;

endpackage

### sv/spbc_front.sv
// Front part: accepts scan points, squares the gap to the previous point and
// tags each point with a break flag before queueing it. Uses spbc_pkg.
module spbc_front import spbc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [GAP_W-1:0]             gap,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_fin,
  input  logic                         q_full,
  output logic                         q_push,
  output cmd_t                         q_cmd
);

  typedef enum logic {F_IDLE, F_PUSH} state_t;

  state_t                      state;
  logic                        have_prev;
  logic                        cur_hp;
  logic                        cur_fin;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [SQ_W-1:0]      sq_x;
  logic signed [SQ_W-1:0]      sq_y;
  logic [T2_W-1:0]             t2;
  logic signed [DIFF_W-1:0]    dx;
  logic signed [DIFF_W-1:0]    dy;
  logic [SUM_W-1:0]            dist_sq;
  logic                        accept;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign dx       = {in_x[COORD_BITS-1], in_x} - {prev_x[COORD_BITS-1], prev_x};
  assign dy       = {in_y[COORD_BITS-1], in_y} - {prev_y[COORD_BITS-1], prev_y};
  assign dist_sq  = SUM_W'($unsigned(sq_x)) + SUM_W'($unsigned(sq_y));
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_cmd    = '{x: cur_x, y: cur_y, brk: cur_hp && (dist_sq > SUM_W'(t2)), fin: cur_fin};

  always_ff @(posedge clk) begin
    t2 <= T2_W'(gap) * T2_W'(gap);
    if (accept) begin
      sq_x    <= SQ_W'(dx) * SQ_W'(dx);
      sq_y    <= SQ_W'(dy) * SQ_W'(dy);
      cur_x   <= in_x;
      cur_y   <= in_y;
      cur_fin <= in_fin;
      prev_x  <= in_x;
      prev_y  <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      have_prev <= 1'b0;
      cur_hp    <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: if (accept) begin
          cur_hp    <= have_prev;
          have_prev <= !in_fin;
          state     <= F_PUSH;
        end
        F_PUSH: if (!q_full) begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/spbc_queue.sv
// Short command queue between the front and back parts.
// Uses cmd_t from spbc_pkg.
module spbc_queue import spbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t            entries [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   used;

  assign full    = (used == (QA_W+1)'(QUEUE_DEPTH));
  assign empty   = (used == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QA_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QA_W'(1);
      if (push && !pop) used <= used + (QA_W+1)'(1);
      else if (pop && !push) used <= used - (QA_W+1)'(1);
    end
  end

endmodule

### sv/spbc_back.sv
// Back part: stores points of the open cluster, closes clusters on a break
// or scan end and replays kept clusters into the output register. Uses spbc_pkg.
module spbc_back import spbc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [MINP_W-1:0]             minp,
  input  logic                          q_empty,
  input  cmd_t                          q_cmd,
  output logic                          q_pop,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic signed [COORD_BITS-1:0]  m_x,
  output logic signed [COORD_BITS-1:0]  m_y,
  output logic [NUM_W-1:0]              m_num,
  output logic                          m_last,
  output logic                          m_trunc,
  output logic                          m_rlast
);

  typedef enum logic [2:0] {B_IDLE, B_CLOSE_GAP, B_APPEND, B_CLOSE_END, B_EMIT} state_t;

  state_t                  state;
  cmd_t                    cur;
  logic [CNT_W-1:0]        count;
  logic                    ovf;
  logic [NUM_W-1:0]        number;
  logic [IDX_W-1:0]        idx;
  logic                    rl_mark;
  logic                    at_end;
  logic [2*COORD_BITS-1:0] store [CLUSTER_DEPTH];
  logic                    emit_ok;
  logic                    min_le1;
  logic                    store_full;
  logic                    emit_last;
  logic                    load;

  assign emit_ok    = (count != '0) && (CMP_W'(count) >= CMP_W'(minp));
  assign min_le1    = (minp < MINP_W'(2));
  assign store_full = (count == CNT_W'(CLUSTER_DEPTH));
  assign emit_last  = (CNT_W'(idx) == count - CNT_W'(1));
  assign load       = (state == B_EMIT) && (!m_valid || m_ready);
  assign q_pop      = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (state == B_APPEND && !store_full) begin
      store[count[IDX_W-1:0]] <= {cur.y, cur.x};
    end
    if (load) begin
      {m_y, m_x} <= store[idx];
      m_num      <= number;
      m_last     <= emit_last;
      m_trunc    <= ovf;
      m_rlast    <= rl_mark && emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      count   <= '0;
      ovf     <= 1'b0;
      number  <= '0;
      idx     <= '0;
      rl_mark <= 1'b0;
      at_end  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (!q_empty) begin
          cur   <= q_cmd;
          state <= q_cmd.brk ? B_CLOSE_GAP : B_APPEND;
        end
        B_CLOSE_GAP: begin
          at_end  <= 1'b0;
          rl_mark <= !(cur.fin && min_le1);
          idx     <= '0;
          if (emit_ok) begin
            state <= B_EMIT;
          end else begin
            count <= '0;
            ovf   <= 1'b0;
            state <= B_APPEND;
          end
        end
        B_APPEND: begin
          if (!store_full) count <= count + CNT_W'(1);
          else ovf <= 1'b1;
          state <= cur.fin ? B_CLOSE_END : B_IDLE;
        end
        B_CLOSE_END: begin
          at_end  <= 1'b1;
          rl_mark <= 1'b1;
          idx     <= '0;
          if (emit_ok) begin
            state <= B_EMIT;
          end else begin
            count  <= '0;
            ovf    <= 1'b0;
            number <= '0;
            state  <= B_IDLE;
          end
        end
        B_EMIT: if (load) begin
          idx <= idx + IDX_W'(1);
          if (emit_last) begin
            count  <= '0;
            ovf    <= 1'b0;
            number <= at_end ? '0 : number + NUM_W'(1);
            state  <= at_end ? B_IDLE : B_APPEND;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### sv/scan_point_breakpoint_clusterer.sv
// Top level of the scan point breakpoint clusterer: configuration registers,
// front, command queue and back. Uses spbc_pkg, spbc_front, spbc_queue, spbc_back.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    tdata {y, x}, tlast scan_end
//   m_*      out        m_tvalid / m_tready    tdata {num, y, x}, tlast, tuser
//   cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes a new point only once the last one is queued (subtract and
// square, then compare and queue). The back spends a dequeue and a store step
// per point, plus a close step per cluster and a replay step per emitted
// point. Reset clears all control state; the cluster store is not cleared.
// Either side may stall; the 4-entry queue and the output register absorb it.
module scan_point_breakpoint_clusterer import spbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y
  input  logic                  s_tlast,   // scan_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_x, out_y, cluster_number
  output logic                  m_tlast,   // cluster_last
  output logic [USER_W-1:0]     m_tuser,   // cluster_truncated, run_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GAP_W-1:0]             gap;
  logic [MINP_W-1:0]            minp;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_empty;
  cmd_t                         push_cmd;
  cmd_t                         pop_cmd;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic [NUM_W-1:0]             out_num;
  logic                         out_trunc;
  logic                         out_rlast;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap  <= GAP_W'(100);
      minp <= MINP_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GAP) gap <= cfg_data;
      else if (cfg_index == REG_MIN) minp <= cfg_data[MINP_W-1:0];
    end
  end

  spbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .gap      (gap),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_x     (s_tdata[COORD_BITS-1:0]),
    .in_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_fin   (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  spbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  spbc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .minp    (minp),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_x     (out_x),
    .m_y     (out_y),
    .m_num   (out_num),
    .m_last  (m_tlast),
    .m_trunc (out_trunc),
    .m_rlast (out_rlast)
  );

  assign m_tdata = OUT_DATA_W'({out_num, out_y, out_x});
  assign m_tuser = {out_rlast, out_trunc};

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("command popped from an empty queue");
  a_run_last_ends_cluster: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && out_rlast) |-> m_tlast)
    else $error("run end flagged inside a cluster");
`endif

endmodule

### test/tb_scan_point_breakpoint_clusterer.sv
// Self-checking testbench for scan_point_breakpoint_clusterer: streams scan points
// with random stalls and checks every emitted cluster point against its own predictor.
// Depends on spbc_pkg and the scan_point_breakpoint_clusterer RTL.
module tb_scan_point_breakpoint_clusterer;
  timeunit 1ns;
  timeprecision 1ps;
  import spbc_pkg::*;

  localparam int REG_COUNT     = 2;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         scan_end;
  } scan_point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [NUM_W-1:0]             num;
    logic                         last;
    logic                         truncated;
    logic                         run_last;
  } cluster_point_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic [USER_W-1:0]     m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scan_point_breakpoint_clusterer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  scan_point_t    pending_points[$];
  cluster_point_t expected_points[$];
  scan_point_t    in_flight;
  int             send_hold;
  int             recv_hold;
  int             quiet_cycles;
  int             error_count;
  bit             idle_on;

  // predictor state
  logic signed [COORD_BITS-1:0] stored_x[CLUSTER_DEPTH];
  logic signed [COORD_BITS-1:0] stored_y[CLUSTER_DEPTH];
  int                           fill_count;
  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  bit                           have_last;
  bit                           lost_points;
  logic [NUM_W-1:0]             cluster_index;
  logic [GAP_W-1:0]             gap_mm;
  logic [MINP_W-1:0]            min_points;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void close_open_cluster();
    cluster_point_t r;
    int i;
    if (fill_count > 0 && fill_count >= min_points) begin
      for (i = 0; i < fill_count; i++) begin
        r.x = stored_x[i];
        r.y = stored_y[i];
        r.num = cluster_index;
        r.last = (i == fill_count - 1);
        r.truncated = lost_points;
        r.run_last = 1'b0;
        expected_points = {expected_points, r};
      end
      cluster_index = cluster_index + 1'b1;
    end
    fill_count = 0;
    lost_points = 1'b0;
  endfunction

  function automatic void predict_point(scan_point_t p);
    longint dx, dy;
    int prior_count;
    cluster_point_t tail;
    prior_count = expected_points.size();
    if (have_last) begin
      dx = longint'($signed(p.x)) - longint'($signed(last_x));
      dy = longint'($signed(p.y)) - longint'($signed(last_y));
      if (dx * dx + dy * dy > longint'(gap_mm) * longint'(gap_mm))
        close_open_cluster();
    end
    if (fill_count < CLUSTER_DEPTH) begin
      stored_x[fill_count] = p.x;
      stored_y[fill_count] = p.y;
      fill_count++;
    end else begin
      lost_points = 1'b1;
    end
    last_x = p.x;
    last_y = p.y;
    have_last = 1'b1;
    if (p.scan_end) begin
      close_open_cluster();
      have_last = 1'b0;
      cluster_index = '0;
    end
    if (expected_points.size() > prior_count) begin
      tail = expected_points[expected_points.size() - 1];
      tail.run_last = 1'b1;
      expected_points[expected_points.size() - 1] = tail;
    end
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    cluster_point_t want, got;
    got.x = m_tdata[COORD_BITS-1:0];
    got.y = m_tdata[2*COORD_BITS-1:COORD_BITS];
    got.num = m_tdata[2*COORD_BITS +: NUM_W];
    got.last = m_tlast;
    got.truncated = m_tuser[0];
    got.run_last = m_tuser[1];
    if (expected_points.size() == 0) begin
      $display("%0t unexpected item: expected none, actual x %0d y %0d cluster %0d",
               $time, got.x, got.y, got.num);
      error_count++;
    end else begin
      want = expected_points.pop_front();
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("cluster_number", want.num, got.num);
      compare_field("cluster_last", want.last, got.last);
      compare_field("cluster_truncated", want.truncated, got.truncated);
      compare_field("run_last", want.run_last, got.run_last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_hold = 0;
    end else begin
      if (s_tvalid && s_tready)
        predict_point(in_flight);
      if (!s_tvalid || s_tready) begin
        if (send_hold > 0) begin
          send_hold--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          send_hold = $urandom_range(0, 3);
          s_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          in_flight = pending_points.pop_front();
          s_tdata <= IN_DATA_W'({in_flight.y, in_flight.x});
          s_tlast <= in_flight.scan_end;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (m_tvalid && m_tready)
        check_result();
      if (recv_hold > 0) begin
        recv_hold--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        recv_hold = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("scan_point_breakpoint_clusterer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_GAP)
      gap_mm = val;
    else if (idx == REG_MIN)
      min_points = val[MINP_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int gap, input int minimum);
    write_reg(REG_GAP, CFG_DATA_W'(gap));
    write_reg(REG_MIN, CFG_DATA_W'(minimum) | (CFG_DATA_W'($urandom_range(0, 63)) << MINP_W));
  endtask

  task automatic push_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y, input logic scan_end);
    scan_point_t p;
    p.x = x;
    p.y = y;
    p.scan_end = scan_end;
    pending_points = {pending_points, p};
  endtask

  // clusters of neighboring points inside the gap, with noise points and stray scan ends
  task automatic queue_scan(input int budget, input bit noise_only);
    int left, len, lim, cx, cy, k;
    left = budget;
    while (left > 0) begin
      if (noise_only || $urandom_range(0, 7) == 0)
        len = 1;
      else if ($urandom_range(0, 5) == 0)
        len = $urandom_range(30, 40);
      else
        len = $urandom_range(1, 8);
      if (len > left)
        len = left;
      lim = gap_mm / 2;
      cx = $urandom;
      cy = $urandom;
      for (k = 0; k < len; k++) begin
        if (k > 0) begin
          cx += int'($urandom_range(0, 2 * lim)) - lim;
          cy += int'($urandom_range(0, 2 * lim)) - lim;
        end
        left--;
        push_point(cx[COORD_BITS-1:0], cy[COORD_BITS-1:0],
                   left == 0 || (!noise_only && $urandom_range(0, 49) == 0));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int gap, input int minimum, input int budget,
                           input bit noise_only);
    set_config(gap, minimum);
    queue_scan(budget, noise_only);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    error_count = 0;
    fill_count = 0;
    last_x = '0;
    last_y = '0;
    have_last = 1'b0;
    lost_points = 1'b0;
    cluster_index = '0;
    gap_mm = GAP_W'(100);
    min_points = MINP_W'(3);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: gap of 100, three points needed
    push_point(0, 0, 1'b0);
    push_point(10, 0, 1'b0);
    push_point(20, 0, 1'b0);
    push_point(32767, 32767, 1'b0);
    push_point(-32768, -32768, 1'b0);
    push_point(-32668, -32768, 1'b0);
    push_point(-32598, -32697, 1'b0);
    push_point(-32527, -32626, 1'b0);
    push_point(-32527, -32627, 1'b1);
    push_point(5, 5, 1'b0);
    push_point(5, 5, 1'b0);
    push_point(6, 6, 1'b1);
    wait_drained();

    // widest gap, single points emitted; gap and scan end on one item
    set_config(4095, 1);
    push_point(0, 0, 1'b0);
    push_point(4095, 0, 1'b0);
    push_point(0, 1, 1'b0);
    push_point(-32768, 32767, 1'b1);
    wait_drained();

    // zero gap and zero minimum; unused register index
    set_config(0, 0);
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 255)), CFG_DATA_W'($urandom));
    push_point(1, 1, 1'b0);
    push_point(1, 1, 1'b0);
    push_point(2, 1, 1'b0);
    push_point(-1, -1, 1'b1);
    wait_drained();

    // minimum above the store depth: nothing emitted
    run_phase(4095, 33, 20, 1'b0);
    run_phase(4095, 63, 15, 1'b0);

    run_phase(100, 3, 40, 1'b0);
    run_phase($urandom_range(0, 4095), $urandom_range(1, 32), 40, 1'b0);
    run_phase(4095, 32, 40, 1'b0);
    run_phase(0, 1, 95, 1'b1);
    idle_on = 1'b0;
    run_phase($urandom_range(0, 300), $urandom_range(1, 4), 40, 1'b0);

    if (error_count == 0)
      $display("scan_point_breakpoint_clusterer test passed");
    else
      $display("scan_point_breakpoint_clusterer test failed");
    $finish;
  end

endmodule

### files.f
sv/spbc_pkg.sv
sv/spbc_front.sv
sv/spbc_queue.sv
sv/spbc_back.sv
sv/scan_point_breakpoint_clusterer.sv
test/tb_scan_point_breakpoint_clusterer.sv
